// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of the list engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ILE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("list engine assertion failed");

// Expression that must never hold at a clock edge out of reset.
`define ILE_ASSERT_NEVER(lbl, expr) \
	`ILE_ASSERT(lbl, !(expr))

`endif

// ===== hw/rtl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types, codes and constants of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned POS_W        = 8;
	localparam int unsigned EIDX_W       = 4;
	// cell index and count width inside the chain (covers the largest capacity)
	localparam int unsigned IDX_W        = 8;

	// operation codes carried on the request word
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_APPEND     = 2'd1,
		OP_DELETE     = 2'd2
	} ile_op_t;

	// per-cycle action broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_APPEND,
		CELL_DELETE,
		CELL_ROTATE
	} ile_cell_op_t;

	typedef struct packed {
		ile_cell_op_t        op;
		logic [IDX_W-1:0]    count;
		logic [IDX_W-1:0]    pos;
		logic [DATA_W-1:0]   value;
	} ile_cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ile_state_t;

endpackage

// ===== hw/rtl/ile_req_if.sv =====
// ----------------------------------------------------------------------------
// ile_req_if
// Request channel: one list operation per word.
// ----------------------------------------------------------------------------
interface ile_req_if
	import ile_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// ===== hw/rtl/ile_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ile_rsp_if
// Response channel: one list entry per word.
// ----------------------------------------------------------------------------
interface ile_rsp_if
	import ile_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element;
	logic [EIDX_W-1:0]        element_index;
	logic                     last_of_run;
	logic                     list_empty;
	logic                     dropped;

	modport source (
		output valid, output element, output element_index,
		output last_of_run, output list_empty, output dropped, input ready
	);
	modport sink (
		input valid, input element, input element_index,
		input last_of_run, input list_empty, input dropped, output ready
	);
endinterface

// ===== hw/rtl/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an entry and trades it with its neighbours.
// ----------------------------------------------------------------------------
module ile_cell
	import ile_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  ile_cell_cmd_t       cmd,
	input  logic [DATA_W-1:0]   left_data,
	input  logic [DATA_W-1:0]   right_data,
	input  logic [DATA_W-1:0]   head_data,
	output logic [DATA_W-1:0]   data
);

	localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(IDX);
	localparam logic [IDX_W-1:0] NEXT_IDX = IDX_W'(IDX + 1);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			CELL_PUSH: begin
				data_d = left_data;
			end
			CELL_APPEND: begin
				if (cmd.count == MY_IDX) begin
					data_d = cmd.value;
				end
			end
			CELL_DELETE: begin
				// close the gap: slots at and above the hole take from the right
				if (MY_IDX >= cmd.pos && NEXT_IDX < cmd.count) begin
					data_d = right_data;
				end
			end
			CELL_ROTATE: begin
				// advance the occupied run by one, front wraps to the back
				if (NEXT_IDX < cmd.count) begin
					data_d = right_data;
				end else if (NEXT_IDX == cmd.count) begin
					data_d = head_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/ile_chain.sv =====
// ----------------------------------------------------------------------------
// ile_chain
// Row of list cells; the front entry sits in cell zero.
// ----------------------------------------------------------------------------
module ile_chain
	import ile_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  ile_cell_cmd_t       cmd,
	output logic [DATA_W-1:0]   head
);

	logic [DATA_W-1:0] cell_data [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cmd.value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		ile_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_data  (left_w),
			.right_data (right_w),
			.head_data  (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

// ===== hw/rtl/indexed_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// Ordered list of signed words held in a row of cells, dumped after each op.
// ----------------------------------------------------------------------------
//  channel | dir | word carries                         | accepted when
//  --------+-----+--------------------------------------+--------------------
//  req     | in  | op, value, position                  | req.valid & req.ready
//  rsp     | out | element, element_index, last_of_run,  | rsp.valid & rsp.ready
//          |     | list_empty, dropped                  |
//
//  An accepted operation is answered by its response words, paced by the
//  single-step rotation of the cell row that brings each entry to the front
//  in turn; no new request is taken until the last word has been sent.
//  Reset clears the entry count and the control state; cell contents are left
//  as they are and never read until written.
//  A stalled rsp holds the current word; the row only rotates on a handshake.
// ----------------------------------------------------------------------------
module indexed_list_engine_top
	import ile_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ile_req_if.sink   req,
	ile_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	ile_state_t        state_q;
	ile_state_t        state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              drop_q;

	ile_cell_cmd_t     cell_cmd;
	logic [DATA_W-1:0] head;

	logic req_fire;
	logic rsp_fire;
	logic list_full;
	logic pos_ok;
	logic last_word;
	logic is_insert;

	// handshakes and operand checks
	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = rsp.valid && rsp.ready;
	assign list_full = (count_q == CAP_CNT);
	assign pos_ok    = (req.position < POS_W'(count_q));
	assign is_insert = (req.op == OP_PUSH_FRONT) || (req.op == OP_APPEND);
	// an empty list still yields a single word, so it is always the last one
	assign last_word = (count_q == '0) || ((idx_q + CNT_W'(1)) == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (rsp_fire && last_word) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and cell command
	always_comb begin
		req.ready      = 1'b0;
		rsp.valid      = 1'b0;
		cell_cmd.op    = CELL_HOLD;
		cell_cmd.count = IDX_W'(count_q);
		cell_cmd.pos   = IDX_W'(req.position);
		cell_cmd.value = req.value;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.op)
						OP_PUSH_FRONT: begin
							if (!list_full) begin
								cell_cmd.op = CELL_PUSH;
							end
						end
						OP_APPEND: begin
							if (!list_full) begin
								cell_cmd.op = CELL_APPEND;
							end
						end
						OP_DELETE: begin
							if (pos_ok) begin
								cell_cmd.op = CELL_DELETE;
							end
						end
						default: begin
							cell_cmd.op = CELL_HOLD;
						end
					endcase
				end
			end
			ST_EMIT: begin
				rsp.valid = 1'b1;
				// advance the row once per word sent; count steps restore order
				if (rsp.ready) begin
					cell_cmd.op = CELL_ROTATE;
				end
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				idx_q  <= '0;
				drop_q <= is_insert && list_full;
				case (req.op)
					OP_PUSH_FRONT, OP_APPEND: begin
						if (!list_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					OP_DELETE: begin
						if (pos_ok) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end else if (rsp_fire) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	ile_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk  (clk),
		.cmd  (cell_cmd),
		.head (head)
	);

	// response word: the front cell always holds the entry being sent
	assign rsp.list_empty    = (count_q == '0);
	assign rsp.element       = rsp.list_empty ? '0 : head;
	assign rsp.element_index = EIDX_W'(idx_q);
	assign rsp.last_of_run   = last_word;
	assign rsp.dropped       = drop_q;

endmodule

// ===== hw/rtl/ile_checker.sv =====
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks on the list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ile_checker
	import ile_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic signed [DATA_W-1:0] rsp_element,
	input logic [EIDX_W-1:0]        rsp_element_index,
	input logic                     rsp_last_of_run,
	input logic                     rsp_list_empty
);

	// a stalled response word holds
	`ILE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element))

	// requests and responses never overlap
	`ILE_ASSERT_NEVER(a_no_overlap, req_ready && rsp_valid)

	// an accepted request is followed by its response run, starting at word index zero
	`ILE_ASSERT(a_run_starts, req_valid && req_ready |=> rsp_valid && rsp_element_index == 0)

	// the run ends after its last word
	`ILE_ASSERT(a_run_ends, rsp_valid && rsp_ready && rsp_last_of_run |=> !rsp_valid)

	// an empty list is a single zero word
	`ILE_ASSERT(a_empty_word, rsp_valid && rsp_list_empty |-> rsp_last_of_run && rsp_element == 0)

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_element       (rsp.element),
	.rsp_element_index (rsp.element_index),
	.rsp_last_of_run   (rsp.last_of_run),
	.rsp_list_empty    (rsp.list_empty)
);

// ===== tb/indexed_list_engine_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_engine_top_test
// Drives list operations into the engine and checks every dumped entry
// against a shadow list kept alongside, under bursty input and stalled output.
// ----------------------------------------------------------------------------
module indexed_list_engine_top_test;
	import ile_pkg::*;

	// op code 3 is not a defined operation; the engine must still dump the list
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned LIST_DEPTH = CAPACITY_DEF;

	// one request word as queued for the driver
	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
		bit                       drain_first; // hold until every dump has arrived
	} list_op_t;

	// one response word as predicted
	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic [EIDX_W-1:0]        element_index;
		logic                     last_of_run;
		logic                     list_empty;
		logic                     dropped;
	} dump_word_t;

	logic clk;
	logic arst_n;

	ile_req_if req_ch ();
	ile_rsp_if rsp_ch ();

	indexed_list_engine_top #(
		.CAPACITY(CAPACITY_DEF)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// pending request words, filled up front by the stimulus block
	list_op_t pending_q[$];
	// shadow copy of the list, front at index 0
	logic signed [DATA_W-1:0] shadow_list[$];
	// dump words still owed by the engine, oldest first
	dump_word_t dump_expect_q[$];

	int unsigned req_sent_cnt = 0;   // words put on the request channel
	int unsigned req_done_cnt = 0;   // words accepted by the engine
	int unsigned mismatch_cnt = 0;
	int unsigned gen_count    = 0;   // list size as tracked while building stimulus
	bit          hold_off     = 0;   // long receiver stall

	// sender burst shaping
	int burst_left = 8;
	int gap_left   = 0;

	// receiver stall pattern
	int unsigned rx_mode      = 0;
	int unsigned rx_mode_left = 50;
	int unsigned rx_tick      = 0;

	// ------------------------------------------------------------------------
	// Clock: 10 ns period
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Shadow list: apply one operation and queue the dump it causes.
	// A refused insert flags every word of its dump; an out-of-range delete
	// and the unused op code leave the list as it is.
	// ------------------------------------------------------------------------
	task automatic predict_dump(
		input logic [OP_W-1:0]          op,
		input logic signed [DATA_W-1:0] value,
		input logic [POS_W-1:0]         position
	);
		dump_word_t w;
		logic       refused;
		int         k;
		refused = 1'b0;
		if (op == OP_PUSH_FRONT || op == OP_APPEND) begin
			if (shadow_list.size() >= LIST_DEPTH)
				refused = 1'b1;
			else if (op == OP_PUSH_FRONT)
				shadow_list.push_front(value);
			else
				shadow_list.push_back(value);
		end else if (op == OP_DELETE) begin
			if (int'(position) < shadow_list.size())
				shadow_list.delete(int'(position));
		end
		if (shadow_list.size() == 0) begin
			// empty list: a single word marked empty, element zero
			w.element       = '0;
			w.element_index = '0;
			w.last_of_run   = 1'b1;
			w.list_empty    = 1'b1;
			w.dropped       = refused;
			dump_expect_q.push_back(w);
		end else begin
			for (k = 0; k < shadow_list.size(); k++) begin
				w.element       = shadow_list[k];
				w.element_index = k[EIDX_W-1:0];
				w.last_of_run   = (k == shadow_list.size() - 1);
				w.list_empty    = 1'b0;
				w.dropped       = refused;
				dump_expect_q.push_back(w);
			end
		end
	endtask

	// Queue one request word and track the list size it leads to, so that
	// delete positions can be aimed inside the list.
	task automatic queue_op(
		input logic [OP_W-1:0]          op,
		input logic signed [DATA_W-1:0] value,
		input logic [POS_W-1:0]         position,
		input bit                       drain_first
	);
		list_op_t item;
		item.op          = op;
		item.value       = value;
		item.position    = position;
		item.drain_first = drain_first;
		pending_q.push_back(item);
		if (op == OP_PUSH_FRONT || op == OP_APPEND) begin
			if (gen_count < LIST_DEPTH)
				gen_count++;
		end else if (op == OP_DELETE) begin
			if (position < gen_count)
				gen_count--;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       pick_value = 32'sh7fff_ffff;
			1:       pick_value = 32'sh8000_0000;
			2:       pick_value = $signed(32'($urandom_range(0, 15)) - 32'd8);
			default: pick_value = $signed($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus: directed corners, then phases that alternately fill and drain
	// the list so that both the full and the empty ends are visited often.
	// ------------------------------------------------------------------------
	task automatic build_stimulus();
		int i;
		int n;
		int phase_left;
		bit filling;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;

		// empty list: delete, unused code
		queue_op(OP_DELETE, 32'sd0, 8'd0, 1'b0);
		queue_op(OP_UNUSED, $signed($urandom), 8'hff, 1'b0);
		// extreme values at both ends
		queue_op(OP_PUSH_FRONT, 32'sh7fff_ffff, 8'h00, 1'b0);
		queue_op(OP_APPEND, 32'sh8000_0000, 8'hff, 1'b0);
		// deletes out of range: far beyond and just at the count
		queue_op(OP_DELETE, 32'sh0, 8'hff, 1'b0);
		queue_op(OP_DELETE, 32'sh0, 8'd2, 1'b0);
		// delete the back, then the front, leaving the list empty
		queue_op(OP_DELETE, 32'sh0, 8'd1, 1'b0);
		queue_op(OP_DELETE, 32'sh0, 8'd0, 1'b0);
		// fill to capacity from both ends
		for (i = 0; i < LIST_DEPTH; i++)
			queue_op((i % 2) ? OP_APPEND : OP_PUSH_FRONT, $signed($urandom), 8'h00, 1'b0);
		// inserts into the full list are refused
		queue_op(OP_PUSH_FRONT, 32'sh1234_5678, 8'h00, 1'b0);
		queue_op(OP_APPEND, -32'sd1, 8'h00, 1'b0);
		queue_op(OP_UNUSED, 32'sh0, 8'h00, 1'b0);
		// middle delete, then one at the count
		queue_op(OP_DELETE, 32'sh0, 8'd7, 1'b0);
		queue_op(OP_DELETE, 32'sh0, 8'd15, 1'b0);

		filling    = 1'b0;
		phase_left = 0;
		for (n = 0; n < 380; n++) begin
			if (phase_left == 0) begin
				filling    = ~filling;
				phase_left = $urandom_range(10, 40);
			end
			phase_left--;
			if ($urandom_range(0, 29) == 0)
				op = OP_UNUSED;
			else if ($urandom_range(0, 3) == 0)
				op = filling ? OP_DELETE : ($urandom_range(0, 1) ? OP_APPEND : OP_PUSH_FRONT);
			else
				op = filling ? ($urandom_range(0, 1) ? OP_APPEND : OP_PUSH_FRONT) : OP_DELETE;
			// mostly aim inside the list, sometimes at the count or anywhere in the field
			if (gen_count > 0 && $urandom_range(0, 4) != 0)
				pos = POS_W'($urandom_range(0, gen_count - 1));
			else if ($urandom_range(0, 1))
				pos = POS_W'(gen_count);
			else
				pos = POS_W'($urandom_range(0, 255));
			queue_op(op, pick_value(), pos, (n == 150 || n == 280));
		end
	endtask

	// ------------------------------------------------------------------------
	// Request driver: change at the falling edge. Hold the word until it is
	// taken; between words follow the burst and gap pattern.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		list_op_t item;
		if (arst_n) begin
			if (!req_ch.valid || req_done_cnt == req_sent_cnt) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_q.size() > 0 &&
						(!pending_q[0].drain_first || dump_expect_q.size() == 0)) begin
					item = pending_q.pop_front();
					req_ch.valid    <= 1'b1;
					req_ch.op       <= item.op;
					req_ch.value    <= item.value;
					req_ch.position <= item.position;
					req_sent_cnt++;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left   = ($urandom_range(0, 5) == 0) ?
							$urandom_range(5, 40) : $urandom_range(0, 3);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response receiver: a stall pattern that changes mode every so often;
	// the long hold-off overrides it.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(20, 300);
			end
			rx_mode_left--;
			rx_tick++;
			case (rx_mode)
				0:       rdy = 1'b1;
				1:       rdy = 1'($urandom_range(0, 1));
				2:       rdy = ($urandom_range(0, 3) == 0);
				default: rdy = (rx_tick % 4 == 0);
			endcase
			rsp_ch.ready <= hold_off ? 1'b0 : rdy;
		end
	end

	// Hold the receiver off long enough for the engine to stall its input.
	initial begin
		wait (req_done_cnt >= 120);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both channels at the rising edge. A taken request word
	// advances the shadow list; a taken response word is checked against the
	// oldest owed word.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		dump_word_t got;
		dump_word_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				predict_dump(req_ch.op, req_ch.value, req_ch.position);
				req_done_cnt++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.element       = rsp_ch.element;
				got.element_index = rsp_ch.element_index;
				got.last_of_run   = rsp_ch.last_of_run;
				got.list_empty    = rsp_ch.list_empty;
				got.dropped       = rsp_ch.dropped;
				if (dump_expect_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected word: element %0d index %0d last %0b empty %0b drop %0b",
							got.element, got.element_index, got.last_of_run,
							got.list_empty, got.dropped);
				end else begin
					want = dump_expect_q.pop_front();
					if (got.element_index != want.element_index ||
							got.last_of_run != want.last_of_run ||
							got.list_empty != want.list_empty ||
							got.dropped != want.dropped ||
							got.element != want.element) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: exp el %0d ix %0d l %0b e %0b d %0b, got el %0d ix %0d l %0b e %0b d %0b",
								want.element, want.element_index, want.last_of_run,
								want.list_empty, want.dropped,
								got.element, got.element_index, got.last_of_run,
								got.list_empty, got.dropped);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset, run the stimulus, drain, report.
	// ------------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.op       = '0;
		req_ch.value    = '0;
		req_ch.position = '0;
		rsp_ch.ready    = 1'b0;
		build_stimulus();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait for every request word to be taken, then for every dump word
		while (pending_q.size() != 0 || req_done_cnt != req_sent_cnt || req_ch.valid)
			@(posedge clk);
		while (dump_expect_q.size() != 0)
			@(posedge clk);
		// catch any stray word after the last dump
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0 && dump_expect_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ile_pkg.sv
hw/rtl/ile_req_if.sv
hw/rtl/ile_rsp_if.sv
hw/rtl/ile_cell.sv
hw/rtl/ile_chain.sv
hw/rtl/indexed_list_engine_top.sv
hw/rtl/ile_checker.sv
tb/indexed_list_engine_top_test.sv
